@@ src/snt_pkg.sv @@
// ----------------------------------------------------------------------------
// snt_pkg: shared types and constants for the sigmoid neuron trainer
// Holds field widths, function codes, queue entry type and Q4.12 helpers.
// ----------------------------------------------------------------------------
package snt_pkg;

  localparam int MaxInputs = 16;
  localparam int DataWidth = 16;
  localparam int FracBits  = 12;
  localparam int IdxW      = 4;
  localparam int CntW      = 5;
  localparam int AccW      = 40;
  localparam int RateW     = 13;
  localparam int QueueDepth = 2;

  localparam logic [1:0] FUNC_FWD   = 2'd0;
  localparam logic [1:0] FUNC_TRAIN = 2'd1;
  localparam logic [1:0] FUNC_WGT   = 2'd2;
  localparam logic [1:0] FUNC_BIAS  = 2'd3;

  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_RATE  = 2'd1;
  localparam logic [1:0] CFG_GAIN  = 2'd2;

  localparam logic KIND_OUT = 1'b0;
  localparam logic KIND_ERR = 1'b1;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]                  func;
    logic signed [DataWidth-1:0] value;
    logic signed [DataWidth-1:0] error_in;
    logic [IdxW-1:0]             weight_index;
    logic                        run_end;
  } job_t;

  // Each error term and each weight update takes three single-multiply steps.
  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC, ST_SUM, ST_SIG, ST_DERIV,
    ST_ERR_A, ST_ERR_B, ST_ERR_C,
    ST_UPD_A, ST_UPD_B, ST_UPD_C,
    ST_BIAS_A, ST_BIAS_B
  } back_state_t;

  function automatic logic signed [DataWidth-1:0] sat16(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd32767;
    lo = -48'sd32768;
    if (v > hi) sat16 = 16'sh7fff;
    else if (v < lo) sat16 = 16'sh8000;
    else sat16 = v[DataWidth-1:0];
  endfunction

  // Product of two Q values, floor shifted by the fraction and saturated.
  function automatic logic signed [DataWidth-1:0] mulq(input logic signed [16:0] a,
                                                        input logic signed [16:0] b);
    logic signed [33:0] p;
    p = a * b;
    mulq = sat16(48'(p >>> FracBits));
  endfunction

  function automatic logic signed [DataWidth-1:0] sigmoid_q(input logic signed [DataWidth-1:0] z);
    logic [16:0] a;
    logic signed [17:0] y;
    a = z[DataWidth-1] ? 17'(-$signed({z[DataWidth-1], z})) : 17'(z);
    if (a >= 17'd20480) y = 18'sd4096;
    else if (a >= 17'd9728) y = 18'(a >> 5) + 18'sd3456;
    else if (a >= 17'd4096) y = 18'(a >> 3) + 18'sd2560;
    else y = 18'(a >> 2) + 18'sd2048;
    if (z[DataWidth-1]) y = 18'sd4096 - y;
    sigmoid_q = sat16(48'(y));
  endfunction

endpackage

@@ src/snt_front.sv @@
// ----------------------------------------------------------------------------
// snt_front: input classifier
// Accepts requests, counts run elements and pushes jobs into a short queue.
// ----------------------------------------------------------------------------
module snt_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [1:0]             s_tuser,
  input  logic [39:0]            s_tdata,
  input  logic [snt_pkg::CntW-1:0] input_count,
  output logic                   q_valid,
  input  logic                   q_ready,
  output snt_pkg::job_t          q_job
);
  import snt_pkg::*;

  job_t            queue [QueueDepth];
  logic            rd_ptr, wr_ptr;
  logic [1:0]      fill;
  logic [CntW-1:0] element_count;
  logic [CntW-1:0] n_eff;
  logic [IdxW-1:0] idx;
  logic            push, pop;
  job_t            in_job;

  always_comb begin
    if (input_count == '0) n_eff = CntW'(1);
    else if (input_count > CntW'(MaxInputs)) n_eff = CntW'(MaxInputs);
    else n_eff = input_count;
    idx = element_count[IdxW-1:0];
    in_job.func         = s_tuser;
    in_job.value        = s_tdata[15:0];
    in_job.error_in     = s_tdata[31:16];
    in_job.weight_index = s_tdata[35:32];
    in_job.run_end      = (CntW'(idx) + CntW'(1)) >= n_eff;
  end

  assign s_tready = (fill != 2'(QueueDepth));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_job    = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
      element_count <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
      if (push && !s_tuser[1]) begin
        element_count <= in_job.run_end ? '0 : CntW'(idx) + CntW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 2'(QueueDepth))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) element_count < CntW'(MaxInputs))
    else $error("element count out of range");
  assert property (@(posedge clk) disable iff (rst) (fill == 2'(QueueDepth)) |-> !s_tready)
    else $error("ready while queue full");

endmodule

@@ src/snt_back.sv @@
// ----------------------------------------------------------------------------
// snt_back: neuron datapath
// Accumulates products, evaluates the sigmoid, emits results, updates weights.
// ----------------------------------------------------------------------------
module snt_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  snt_pkg::job_t             q_job,
  input  logic [snt_pkg::CntW-1:0]  input_count,
  input  logic [snt_pkg::RateW-1:0] train_rate,
  input  logic [snt_pkg::RateW-1:0] momentum_gain,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [23:0]               m_tdata,
  output logic                      m_tlast
);
  import snt_pkg::*;

  back_state_t state, state_next;
  logic signed [DataWidth-1:0] weight_store [MaxInputs];
  logic signed [DataWidth-1:0] input_store  [MaxInputs];
  logic signed [DataWidth-1:0] bias_reg;
  logic signed [AccW-1:0]      accumulator;
  logic signed [31:0]          product;
  logic [IdxW-1:0]             mac_idx;
  logic [IdxW-1:0]             step;
  logic [CntW-1:0]             n_eff;
  logic signed [DataWidth-1:0] z, o, d, err, chain;
  logic                        is_train, last_step;
  logic                        out_valid, out_kind, out_last, out_load;
  logic [IdxW-1:0]             out_index;
  logic signed [DataWidth-1:0] out_value;
  logic                        out_free, take;
  logic [IdxW-1:0]             elem_idx;
  logic                        q_run_end;
  logic signed [DataWidth-1:0] cur_value;
  logic [1:0]                  cur_func;

  assign out_free = !out_valid || m_tready;
  assign n_eff = (input_count == '0) ? CntW'(1) :
                 (input_count > CntW'(MaxInputs)) ? CntW'(MaxInputs) : input_count;
  assign last_step = (CntW'(step) + CntW'(1)) >= n_eff;
  assign q_ready = (state == ST_IDLE);
  assign take = q_valid && q_ready;
  assign out_load = out_free && (((state == ST_DERIV) && !is_train) || (state == ST_ERR_C));

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (q_valid) state_next = q_job.func[1] ? ST_IDLE : ST_MAC;
      ST_MAC:    state_next = q_run_end ? ST_SUM : ST_IDLE;
      ST_SUM:    state_next = ST_SIG;
      ST_SIG:    state_next = ST_DERIV;
      ST_DERIV:  if (out_free) state_next = is_train ? ST_ERR_A : ST_IDLE;
      ST_ERR_A:  state_next = ST_ERR_B;
      ST_ERR_B:  state_next = ST_ERR_C;
      ST_ERR_C:  if (out_free) state_next = last_step ? ST_UPD_A : ST_ERR_A;
      ST_UPD_A:  state_next = ST_UPD_B;
      ST_UPD_B:  state_next = ST_UPD_C;
      ST_UPD_C:  state_next = last_step ? ST_BIAS_A : ST_UPD_A;
      ST_BIAS_A: state_next = ST_BIAS_B;
      ST_BIAS_B: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_value <= q_job.value;
      cur_func  <= q_job.func;
      err       <= q_job.error_in;
      q_run_end <= q_job.run_end;
    end
  end

  assign elem_idx = mac_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxInputs; i++) weight_store[i] <= '0;
      bias_reg <= '0;
      accumulator <= '0;
      mac_idx <= '0;
      step <= '0;
      out_valid <= 1'b0;
      is_train <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (take && q_job.func == FUNC_WGT)
            weight_store[q_job.weight_index] <= q_job.value;
          if (take && q_job.func == FUNC_BIAS) bias_reg <= q_job.value;
          if (take && !q_job.func[1])
            product <= q_job.value * weight_store[mac_idx];
        end
        ST_MAC: begin
          input_store[elem_idx] <= cur_value;
          accumulator <= accumulator + AccW'(product);
          mac_idx <= q_run_end ? '0 : mac_idx + IdxW'(1);
          is_train <= (cur_func == FUNC_TRAIN);
        end
        ST_SUM: begin
          z <= sat16(48'((accumulator + (AccW'(bias_reg) <<< FracBits)) >>> FracBits));
          accumulator <= '0;
        end
        ST_SIG: begin
          o <= sigmoid_q(z);
        end
        ST_DERIV: begin
          d <= mulq(17'(o), 17'(18'sd4096 - 18'(o)));
          step <= '0;
          if (out_load) begin
            out_kind  <= KIND_OUT;
            out_index <= '0;
            out_value <= o;
            out_last  <= 1'b1;
          end
        end
        // Error term w*err*d*gain, one product per cycle; ST_ERR_C waits while the output is held.
        ST_ERR_A: chain <= mulq(17'(weight_store[step]), 17'(err));
        ST_ERR_B: chain <= mulq(17'(chain), 17'(d));
        ST_ERR_C: begin
          if (out_free) begin
            out_kind  <= KIND_ERR;
            out_index <= step;
            out_value <= mulq(17'(chain), {4'b0, momentum_gain});
            out_last  <= last_step;
            step <= last_step ? '0 : step + IdxW'(1);
          end
        end
        // Weight step x*d*err*rate, one product per cycle.
        ST_UPD_A: chain <= mulq(17'(input_store[step]), 17'(d));
        ST_UPD_B: chain <= mulq(17'(chain), 17'(err));
        ST_UPD_C: begin
          weight_store[step] <= sat16(48'(weight_store[step]) -
                                      48'(mulq(17'(chain), {4'b0, train_rate})));
          step <= last_step ? '0 : step + IdxW'(1);
        end
        ST_BIAS_A: chain <= mulq(17'(d), 17'(err));
        ST_BIAS_B: begin
          bias_reg <= sat16(48'(bias_reg) - 48'(mulq(17'(chain), {4'b0, train_rate})));
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b0, out_value, out_index, out_kind};
  assign m_tlast  = out_last;

  assert property (@(posedge clk) disable iff (rst) (state != ST_IDLE) |-> !q_ready)
    else $error("back accepts while busy");
  assert property (@(posedge clk) disable iff (rst) (state == ST_BIAS_B) |=> (state == ST_IDLE))
    else $error("bias step not followed by idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |=> (accumulator == '0))
    else $error("accumulator not cleared after run");

endmodule

@@ src/sigmoid_neuron_train_top.sv @@
// Flow: an accepted element is written into the queue, taken by the back part in ST_IDLE
// and accumulated in ST_MAC; a run's last element then passes ST_SUM, ST_SIG and ST_DERIV,
// where the neuron output is registered. The back part takes no new element until it is idle
// again. A train run then emits n error terms and afterwards updates the weights and bias.
// Reset: synchronous active-high rst clears weights, bias, accumulator, counts,
// registers to defaults (count 16, rate 0.3, gain 0.9) and empties the queue.
// ----------------------------------------------------------------------------
// sigmoid_neuron_train_top: trainable sigmoid neuron
// Front classifier, two-entry queue and back datapath with config registers.
// ----------------------------------------------------------------------------
module sigmoid_neuron_train_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[15:0], error_in[31:16], weight_index[35:32]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // kind[0], out_index[4:1], out_value[20:5]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import snt_pkg::*;

  logic [CntW-1:0]  input_count;
  logic [RateW-1:0] train_rate, momentum_gain;
  logic             q_valid, q_ready;
  job_t             q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count   <= CntW'(16);
      train_rate    <= RateW'(1229);
      momentum_gain <= RateW'(3686);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COUNT: input_count   <= cfg_data[CntW-1:0];
        CFG_RATE:  train_rate    <= cfg_data;
        CFG_GAIN:  momentum_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  snt_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
    .input_count, .q_valid, .q_ready, .q_job
  );

  snt_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_job, .input_count,
    .train_rate, .momentum_gain, .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

endmodule

@@ test/sigmoid_neuron_train_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigmoid_neuron_train_top_tb: self-checking bench for the trainable neuron
// Streams forward, train and parameter-write requests under random idling,
// predicts every result in Q4.12 and checks outputs field by field.
// ----------------------------------------------------------------------------
module sigmoid_neuron_train_top_tb;
  import snt_pkg::*;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] value;
    logic [15:0] error_in;
    logic [3:0]  widx;
  } neuron_req_t;

  typedef struct {
    logic        kind;
    logic [3:0]  idx;
    logic [15:0] value;
    logic        last;
  } neuron_res_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  sigmoid_neuron_train_top dut (.*);

  neuron_req_t req_pending[$];
  neuron_res_t res_expected[$];
  neuron_req_t req_cur;

  // Model of the neuron state.
  longint wts[16];
  longint xs[16];
  longint bias_q;
  longint acc;
  int     elem_cnt;
  int     n_inputs;
  longint rate_q;
  longint gain_q;

  int  errors;
  int  sent_cnt;
  int  taken_cnt;
  int  tx_gap;
  int  rx_gap;
  int  cycle;
  int  hold_until;
  bit  no_idle;
  int  n_outputs;
  int  n_terms;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint fshift(longint v);
    return v >>> 12;
  endfunction

  function automatic longint sat_q(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat_q(fshift(a * b));
  endfunction

  function automatic longint logistic(longint z);
    longint a;
    longint y;
    a = z < 0 ? -z : z;
    if (a >= 20480) y = 4096;
    else if (a >= 9728) y = (a >>> 5) + 3456;
    else if (a >= 4096) y = (a >>> 3) + 2560;
    else y = (a >>> 2) + 2048;
    return sat_q(z < 0 ? 4096 - y : y);
  endfunction

  task automatic predict_neuron(input neuron_req_t r);
    longint v;
    longint e;
    longint o;
    longint d;
    longint t;
    int n;
    int idx;
    neuron_res_t res;
    v = longint'($signed(r.value));
    e = longint'($signed(r.error_in));
    if (r.func == FUNC_WGT) begin
      wts[r.widx] = v;
    end else if (r.func == FUNC_BIAS) begin
      bias_q = v;
    end else begin
      n = n_inputs < 1 ? 1 : (n_inputs > MaxInputs ? MaxInputs : n_inputs);
      idx = elem_cnt < MaxInputs ? elem_cnt : MaxInputs - 1;
      xs[idx] = v;
      acc += v * wts[idx];
      if (idx + 1 < n) begin
        elem_cnt = idx + 1;
      end else begin
        o = logistic(sat_q(fshift(acc + bias_q * 4096)));
        acc = 0;
        elem_cnt = 0;
        if (r.func == FUNC_FWD) begin
          res = '{KIND_OUT, 4'd0, o[15:0], 1'b1};
          res_expected.push_back(res);
        end else begin
          d = fshift(o * (4096 - o));
          for (int i = 0; i < n; i++) begin
            t = qmul(qmul(qmul(wts[i], e), d), gain_q);
            res = '{KIND_ERR, i[3:0], t[15:0], (i + 1 == n)};
            res_expected.push_back(res);
          end
          for (int i = 0; i < n; i++)
            wts[i] = sat_q(wts[i] - qmul(qmul(qmul(xs[i], d), e), rate_q));
          bias_q = sat_q(bias_q - qmul(qmul(d, e), rate_q));
        end
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Sender: a request stays on the bus until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && taken_cnt != sent_cnt)) begin
      if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        s_tvalid <= 1'b0;
      end else if (req_pending.size() > 0) begin
        req_cur = req_pending.pop_front();
        s_tdata <= {4'b0, req_cur.widx, req_cur.error_in, req_cur.value};
        s_tuser <= req_cur.func;
        s_tvalid <= 1'b1;
        sent_cnt = sent_cnt + 1;
        tx_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      taken_cnt = taken_cnt + 1;
      predict_neuron(req_cur);
    end
  end

  // Receiver with random stalls and a long hold-off window.
  always @(negedge clk) begin
    if (rst || cycle < hold_until) begin
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      rx_gap = pick_gap();
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("ERROR at cycle %0d: %s got %0d expected %0d", cycle, what, got, want);
    errors = errors + 1;
  endtask

  always @(posedge clk) begin
    neuron_res_t w;
    cycle = cycle + 1;
    if (cycle > 200000) begin
      $display("sigmoid_neuron_train_top test failed");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (res_expected.size() == 0) begin
        report("unexpected result, out_value", int'($signed(m_tdata[20:5])), 0);
      end else begin
        w = res_expected.pop_front();
        if (m_tdata[0] !== w.kind) report("kind", m_tdata[0], w.kind);
        if (m_tdata[4:1] !== w.idx) report("out_index", m_tdata[4:1], w.idx);
        if (m_tdata[20:5] !== w.value)
          report("out_value", int'($signed(m_tdata[20:5])), int'($signed(w.value)));
        if (m_tlast !== w.last) report("last", m_tlast, w.last);
        if (m_tdata[23:21] !== 3'b0) report("tdata pad", m_tdata[23:21], 0);
        if (w.kind == KIND_OUT) n_outputs++;
        else n_terms++;
      end
    end
  end

  task automatic add_req(input logic [1:0] f, input int v, input int e, input int wi);
    neuron_req_t r;
    r = '{f, v[15:0], e[15:0], wi[3:0]};
    req_pending.push_back(r);
  endtask

  // The weight and bias updates run on after the last error term leaves.
  task automatic wait_idle();
    while (req_pending.size() > 0 || taken_cnt != sent_cnt || res_expected.size() > 0)
      @(posedge clk);
    repeat (96) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] ri, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= val[12:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (ri == CFG_COUNT) n_inputs = val & 31;
    else if (ri == CFG_RATE) rate_q = val & 8191;
    else if (ri == CFG_GAIN) gain_q = val & 8191;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int rand_q();
    case ($urandom_range(3))
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(8192) - 4096;
      2: return $urandom_range(2048) - 1024;
      default: return $urandom_range(1) ? 32767 : -32768;
    endcase
  endfunction

  task automatic add_random(input int cnt);
    int r;
    for (int k = 0; k < cnt; k++) begin
      r = $urandom_range(99);
      if (r < 12) add_req(FUNC_WGT, rand_q(), $urandom_range(65535), $urandom_range(15));
      else if (r < 18) add_req(FUNC_BIAS, rand_q(), $urandom_range(65535), $urandom_range(15));
      else add_req($urandom_range(1) ? FUNC_TRAIN : FUNC_FWD, rand_q(), rand_q(),
                   $urandom_range(15));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0; sent_cnt = 0; taken_cnt = 0; tx_gap = 0; rx_gap = 0;
    cycle = 0; hold_until = 0; no_idle = 1'b0; n_outputs = 0; n_terms = 0;
    foreach (wts[i]) begin
      wts[i] = 0;
      xs[i] = 0;
    end
    bias_q = 0; acc = 0; elem_cnt = 0;
    n_inputs = 16; rate_q = 1229; gain_q = 3686;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes of every field, both modes, mixed-mode runs.
    write_reg(CFG_COUNT, 2);
    add_req(FUNC_WGT, 32767, 0, 0);
    add_req(FUNC_WGT, -32768, -1, 1);
    add_req(FUNC_WGT, 1234, 0, 15);
    add_req(FUNC_BIAS, 32767, 0, 0);
    add_req(FUNC_FWD, 32767, 0, 15);
    add_req(FUNC_FWD, -32768, 0, 0);
    add_req(FUNC_BIAS, -32768, 0, 0);
    add_req(FUNC_TRAIN, -32768, 32767, 0);
    add_req(FUNC_TRAIN, 32767, -32768, 15);
    add_req(FUNC_FWD, 4096, 0, 0);
    add_req(FUNC_TRAIN, -4096, 2048, 0);
    add_req(FUNC_TRAIN, 2000, 0, 0);
    add_req(FUNC_FWD, -2000, -4096, 0);
    add_req(FUNC_BIAS, 0, 0, 0);
    add_req(FUNC_TRAIN, 0, -1, 0);
    add_req(FUNC_WGT, 500, 0, 1);
    add_req(FUNC_TRAIN, 0, 0, 0);
    wait_idle();

    // Random phases across register settings, extremes included.
    write_reg(CFG_COUNT, 1); write_reg(CFG_RATE, 0); write_reg(CFG_GAIN, 0);
    add_random(14);
    wait_idle();
    write_reg(CFG_COUNT, 5); write_reg(CFG_RATE, 4096); write_reg(CFG_GAIN, 4096);
    no_idle = 1'b1;
    add_random(13);
    wait_idle();
    no_idle = 1'b0;
    // A partial run is left open; the lowered count ends it on the next element.
    write_reg(CFG_COUNT, 0); write_reg(CFG_RATE, 8191); write_reg(CFG_GAIN, 8191);
    add_random(12);
    wait_idle();
    // Full-width train runs while the receiver holds off for a long stretch.
    write_reg(CFG_COUNT, 31); write_reg(CFG_RATE, 1229); write_reg(CFG_GAIN, 3686);
    hold_until = cycle + 400;
    for (int k = 0; k < 16; k++) add_req(FUNC_TRAIN, rand_q(), rand_q(), 0);
    add_random(20);
    wait_idle();
    write_reg(CFG_COUNT, 3);
    write_reg(CFG_RATE, $urandom_range(8191));
    write_reg(CFG_GAIN, $urandom_range(8191));
    add_random(24);
    wait_idle();

    $display("Covered %0d requests: %0d neuron outputs and %0d error terms checked.",
             sent_cnt, n_outputs, n_terms);
    $display("Input counts 0..31, rate and gain from 0 to 8191, long output stall.");
    if (errors == 0) begin
      $display("sigmoid_neuron_train_top test passed");
    end else begin
      $display("sigmoid_neuron_train_top test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/snt_pkg.sv
src/snt_front.sv
src/snt_back.sv
src/sigmoid_neuron_train_top.sv
test/sigmoid_neuron_train_top_tb.sv
